// ===== design/ist_pkg.sv =====
// Package for the interval set table: payload structs, request codes, FSM states.
// No dependencies.
`default_nettype none
package ist_pkg;
  localparam int unsigned OFS_W = 31;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned TOT_W = 35;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [OFS_W-1:0]  offset;
    logic signed [LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [TOT_W-1:0]  total_length;
    logic              has_unbounded;
    logic [CNT_W-1:0]  entry_count;
    logic              overflow_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_PROC,
    ST_CHECK,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SUM,
    ST_ACC,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== design/interval_set_table_top.sv =====
// Interval set table top: request sequencer over a main and a work memory.
// Depends on ist_pkg and ist_mem.
//
// Usage: present a request on in_item with start high while busy is low; the
// request transfers at that edge and busy rises the next cycle. An insert or
// remove of length zero is ignored. A query, an insert or a remove walks the
// N stored entries from the main memory (a registered read, then processing),
// and an insert or remove writes the new list of M entries into a work memory;
// a split or a merge adds one more write step. A successful insert or remove
// then copies the work list back, and every request sums the F finite lengths.
// busy stays high through the result cycle; the next request can transfer in
// the cycle after it. One request at a time.
// The result appears on out_item for exactly one cycle with out_valid high.
// The receiver cannot stall.
// Reset (synchronous, rst_n low) empties the set; memory contents stay
// undefined and are never used past the entry count.
`default_nettype none
module interval_set_table_top
  import ist_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output logic           busy,
  output logic           out_valid,
  output out_item_t      out_item
);
  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned NW = $clog2(MAX_INTERVALS + 3);
  localparam int unsigned EW = 33;
  localparam logic [NW-1:0] MAXN = NW'(MAX_INTERVALS);
  localparam logic [EW-1:0] F31 = {2'b00, {31{1'b1}}};
  localparam logic [1:0] PH_PRE   = 2'd0;
  localparam logic [1:0] PH_MERGE = 2'd1;
  localparam logic [1:0] PH_COPY  = 2'd2;

  state_t state_r, state_nxt;
  logic [1:0]    type_r, type_nxt;
  logic [EW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic          unb_r, unb_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          lu_r, lu_nxt;
  logic [NW-1:0] i_r, i_nxt;
  logic [NW-1:0] wn_r, wn_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [EW-1:0] ns_r, ns_nxt, ne_r, ne_nxt;
  logic          nu_r, nu_nxt;
  logic          hit_r, hit_nxt;
  logic          ovf_r, ovf_nxt;
  logic          wbad_r, wbad_nxt;
  logic          wlu_r, wlu_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt;
  logic          pend_r, pend_nxt;
  logic [EW-1:0] pds_r, pds_nxt, pde_r, pde_nxt;
  logic          pdu_r, pdu_nxt;

  logic          m_we, w_we;
  logic [AW-1:0] m_wa, m_ra, w_wa, w_ra;
  logic [61:0]   m_wd, m_rd, w_wd, w_rd;

  ist_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(62)) u_main (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  ist_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(62)) u_work (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

  logic [EW-1:0] es, ee;
  logic          eu;
  assign es = {2'b00, m_rd[61:31]};
  assign ee = es + {2'b00, m_rd[30:0]};
  assign eu = lu_r && (i_r + NW'(1) == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lu_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lu_r    <= lu_nxt;
    end
    type_r <= type_nxt; a_r <= a_nxt; b_r <= b_nxt; unb_r <= unb_nxt;
    i_r <= i_nxt; wn_r <= wn_nxt; phase_r <= phase_nxt;
    ns_r <= ns_nxt; ne_r <= ne_nxt; nu_r <= nu_nxt;
    hit_r <= hit_nxt; ovf_r <= ovf_nxt; wbad_r <= wbad_nxt; wlu_r <= wlu_nxt;
    tot_r <= tot_nxt; pend_r <= pend_nxt;
    pds_r <= pds_nxt; pde_r <= pde_nxt; pdu_r <= pdu_nxt;
  end

  always_comb begin
    logic [EW-1:0] rs, ws, wend;
    logic          wr, wu;
    logic [NW-1:0] nfin;
    state_nxt = state_r;
    type_nxt = type_r; a_nxt = a_r; b_nxt = b_r; unb_nxt = unb_r;
    cnt_nxt = cnt_r; lu_nxt = lu_r; i_nxt = i_r; wn_nxt = wn_r;
    phase_nxt = phase_r; ns_nxt = ns_r; ne_nxt = ne_r; nu_nxt = nu_r;
    hit_nxt = hit_r; ovf_nxt = ovf_r; wbad_nxt = wbad_r; wlu_nxt = wlu_r;
    tot_nxt = tot_r; pend_nxt = pend_r;
    pds_nxt = pds_r; pde_nxt = pde_r; pdu_nxt = pdu_r;
    m_we = 1'b0; m_wa = i_r[AW-1:0]; m_wd = w_rd; m_ra = i_r[AW-1:0];
    w_we = 1'b0; w_wa = wn_r[AW-1:0]; w_ra = i_r[AW-1:0]; w_wd = '0;
    rs = '0; ws = '0; wend = '0; wr = 1'b0; wu = 1'b0;
    nfin = (lu_r && cnt_r != '0) ? cnt_r - NW'(1) : cnt_r;
    busy = (state_r != ST_IDLE);
    out_valid = 1'b0;
    out_item = '0;
    out_item.hit = hit_r;
    out_item.total_length = tot_r;
    out_item.has_unbounded = lu_r;
    out_item.entry_count = CNT_W'(cnt_r);
    out_item.overflow_error = ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          type_nxt = in_item.req_type;
          a_nxt = {2'b00, in_item.offset};
          unb_nxt = in_item.length[LEN_W-1];
          b_nxt = in_item.length[LEN_W-1] ? '0 :
                  {2'b00, in_item.offset} + {1'b0, in_item.length};
          ns_nxt = {2'b00, in_item.offset};
          ne_nxt = in_item.length[LEN_W-1] ? '0 :
                   {2'b00, in_item.offset} + {1'b0, in_item.length};
          nu_nxt = in_item.length[LEN_W-1];
          i_nxt = '0; wn_nxt = '0; phase_nxt = PH_PRE;
          hit_nxt = 1'b0; ovf_nxt = 1'b0; wbad_nxt = 1'b0; wlu_nxt = 1'b0;
          tot_nxt = '0; pend_nxt = 1'b0;
          if ((in_item.req_type == REQ_INSERT || in_item.req_type == REQ_REMOVE) &&
              in_item.length == '0)
            type_nxt = REQ_NONE;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // main read of entry i_r issued; data valid next cycle
        if (pend_r) begin
          wr = 1'b1; ws = pds_r; wend = pde_r; wu = pdu_r;
          pend_nxt = 1'b0;
        end else if (type_r == REQ_NONE) begin
          i_nxt = '0;
          state_nxt = ST_SUM;
        end else if (i_r < cnt_r) begin
          state_nxt = ST_PROC;
        end else if (type_r == REQ_INSERT && phase_r != PH_COPY) begin
          // merged piece closes the list
          wr = 1'b1; ws = ns_r; wend = ne_r; wu = nu_r;
          phase_nxt = PH_COPY;
        end else if (type_r == REQ_QUERY) begin
          i_nxt = '0;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_PROC: begin
        state_nxt = ST_RD;
        i_nxt = i_r + NW'(1);
        unique case (type_r)
          REQ_QUERY: begin
            if (eu) begin
              if (unb_r || b_r > es) hit_nxt = 1'b1;
            end else if (a_r < ee && (unb_r || b_r > es)) hit_nxt = 1'b1;
          end
          REQ_REMOVE: begin
            rs = (es > b_r) ? es : b_r;
            if (es < a_r) begin
              wr = 1'b1; ws = es; wend = (eu || ee > a_r) ? a_r : ee; wu = 1'b0;
              if (!unb_r && (eu || rs < ee)) begin
                pend_nxt = 1'b1; pds_nxt = rs; pde_nxt = ee; pdu_nxt = eu;
              end
            end else if (!unb_r && (eu || rs < ee)) begin
              wr = 1'b1; ws = rs; wend = ee; wu = eu;
            end
          end
          REQ_INSERT: begin
            if (phase_r == PH_COPY) begin
              wr = 1'b1; ws = es; wend = ee; wu = eu;
            end else if (phase_r == PH_PRE && !(eu || ee >= a_r)) begin
              wr = 1'b1; ws = es; wend = ee; wu = 1'b0;
            end else if (!nu_r && es > ne_r) begin
              // merged piece, then this entry
              wr = 1'b1; ws = ns_r; wend = ne_r; wu = 1'b0;
              pend_nxt = 1'b1; pds_nxt = es; pde_nxt = ee; pdu_nxt = eu;
              phase_nxt = PH_COPY;
            end else begin
              phase_nxt = PH_MERGE;
              if (es < ns_r) ns_nxt = es;
              if (eu) nu_nxt = 1'b1;
              else if (ee > ne_r) ne_nxt = ee;
              if (eu || nu_r) i_nxt = cnt_r;
            end
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        i_nxt = '0;
        if (wn_r > MAXN || wbad_r) begin
          ovf_nxt = 1'b1;
          state_nxt = ST_SUM;
        end else begin
          cnt_nxt = wn_r;
          lu_nxt = (wn_r != '0) && wlu_r;
          state_nxt = ST_COPY_RD;
        end
      end
      ST_COPY_RD: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_COPY_WR;
        end
      end
      ST_COPY_WR: begin
        m_we = 1'b1;
        i_nxt = i_r + NW'(1);
        state_nxt = ST_COPY_RD;
      end
      ST_SUM: begin
        state_nxt = (i_r < nfin) ? ST_ACC : ST_DONE;
      end
      ST_ACC: begin
        tot_nxt = tot_r + TOT_W'(m_rd[30:0]);
        i_nxt = i_r + NW'(1);
        state_nxt = ST_SUM;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (wr) begin
      if (ws > F31 || (!wu && wend - ws > F31)) wbad_nxt = 1'b1;
      w_we = (wn_r < MAXN);
      w_wd = {ws[30:0], wu ? 31'd0 : 31'(wend - ws)};
      wlu_nxt = wu;
      wn_nxt = wn_r + NW'(1);
    end
  end

  property p_cnt_cap;
    @(posedge clk) disable iff (!rst_n) out_valid |-> (cnt_r <= MAXN);
  endproperty
  assert property (p_cnt_cap) else $error("entry count beyond capacity");

  property p_out_one_cycle;
    @(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid;
  endproperty
  assert property (p_out_one_cycle) else $error("result strobe held");

  property p_busy_after_start;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy;
  endproperty
  assert property (p_busy_after_start) else $error("transfer did not raise busy");

  property p_ovf_keeps_count;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_item.overflow_error) |-> $stable(cnt_r);
  endproperty
  assert property (p_ovf_keeps_count) else $error("overflow changed the set");
endmodule
`default_nettype wire

// ===== design/ist_mem.sv =====
// Simple dual-port synchronous RAM (one write, one registered read).
// Depends on nothing.
`default_nettype none
module ist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
